[sv/assert_macros.svh]
// Assertion shorthands used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VT4_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VT4_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define VT4_ASSERT(lbl, clk, rst_n, prop, msg)
`define VT4_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

[sv/vt4_pkg.sv]
package vt4_pkg;

  localparam int DATA_W  = 16;
  localparam int LANE_W  = 16;
  localparam int ROW_W   = 64;
  localparam int NUM_ROWS = 4;
  // Vector elements carry two extra magnitude bits so that 1.0 fits at 16 fraction bits.
  localparam int VEC_W   = 18;
  // Quotient bits resolved by the divider; larger quotients saturate.
  localparam int Q_BITS  = 16;

  localparam logic [DATA_W-1:0] Q_POS_MAX = 16'h7FFF;
  localparam logic [DATA_W-1:0] Q_NEG_MAX = 16'h8000;

  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_ROW3 = 2'd3
  } vt4_reg_t;

  typedef enum logic {
    CMD_HOMOG = 1'b0,
    CMD_PERSP = 1'b1
  } vt4_cmd_t;

  // Per-transaction data that rides alongside the divider.
  typedef struct packed {
    vt4_cmd_t                   cmd;
    logic                       zero_w;
    logic [2:0]                 neg;
    logic [3:0][DATA_W-1:0]     rnd;
  } vt4_side_t;

endpackage

[sv/vt4_mac.sv]
module vt4_mac #(
  parameter int FRAC_BITS   = 8,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  vt4_pkg::vt4_cmd_t        in_cmd,
  input  logic signed [15:0]       vx,
  input  logic signed [15:0]       vy,
  input  logic signed [15:0]       vz,
  input  logic signed [15:0]       vw,
  input  logic [vt4_pkg::ROW_W-1:0] rows [vt4_pkg::NUM_ROWS],
  input  logic                     en_dn,
  output logic                     en_up,
  output logic                     out_valid,
  output vt4_pkg::vt4_cmd_t        out_cmd,
  output logic signed [COEFF_WIDTH+vt4_pkg::VEC_W+1:0] acc [vt4_pkg::NUM_ROWS]
);

  localparam int VEC_W  = vt4_pkg::VEC_W;
  localparam int PROD_W = COEFF_WIDTH + VEC_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [VEC_W-1:0] W_ONE = VEC_W'(2 ** FRAC_BITS);

  logic signed [VEC_W-1:0]       vec [4];
  logic signed [COEFF_WIDTH-1:0] coef [4][4];

  logic                    v1_r, v2_r, v3_r;
  vt4_pkg::vt4_cmd_t       cmd1_r, cmd2_r, cmd3_r;
  logic signed [PROD_W-1:0] prod_r [4][4];
  logic signed [PROD_W:0]   sum_r [4][2];
  logic signed [ACC_W-1:0]  acc_r [4];
  logic en1, en2, en3;

  assign en3   = !v3_r || en_dn;
  assign en2   = !v2_r || en3;
  assign en1   = !v1_r || en2;
  assign en_up = en1;

  always_comb begin
    vec[0] = VEC_W'(vx);
    vec[1] = VEC_W'(vy);
    vec[2] = VEC_W'(vz);
    vec[3] = (in_cmd == vt4_pkg::CMD_PERSP) ? W_ONE : VEC_W'(vw);
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign coef[r][c] = rows[r][vt4_pkg::LANE_W*c +: COEFF_WIDTH];

      always_ff @(posedge clk) begin
        if (en1) begin
          prod_r[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(vec[c]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en2) begin
        sum_r[r][0] <= (PROD_W+1)'(prod_r[r][0]) + (PROD_W+1)'(prod_r[r][1]);
        sum_r[r][1] <= (PROD_W+1)'(prod_r[r][2]) + (PROD_W+1)'(prod_r[r][3]);
      end
      if (en3) begin
        acc_r[r] <= ACC_W'(sum_r[r][0]) + ACC_W'(sum_r[r][1]);
      end
    end

    assign acc[r] = acc_r[r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) cmd1_r <= in_cmd;
    if (en2) cmd2_r <= cmd1_r;
    if (en3) cmd3_r <= cmd2_r;
  end

  assign out_valid = v3_r;
  assign out_cmd   = cmd3_r;

endmodule

[sv/vt4_div.sv]
module vt4_div #(
  parameter int ACC_W = 36,
  parameter int NUM_W = 60
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  vt4_pkg::vt4_side_t           in_side,
  input  logic [NUM_W-1:0]             in_num [3],
  input  logic [ACC_W-1:0]             in_den,
  input  logic                         en_dn,
  output logic                         en_up,
  output logic                         out_valid,
  output vt4_pkg::vt4_side_t           out_side,
  output logic [vt4_pkg::Q_BITS-1:0]   out_quo [3],
  output logic [2:0]                   out_ovf
);

  localparam int QB = vt4_pkg::Q_BITS;

  logic [QB:0]            v_r;
  logic [QB+1:0]          en;
  vt4_pkg::vt4_side_t     side_r [QB+1];
  logic [ACC_W-1:0]       den_r  [QB+1];
  logic [NUM_W-1:0]       rem_r  [QB+1][3];
  logic [QB-1:0]          quo_r  [QB+1][3];
  logic [2:0]             ovf_r  [QB+1];

  assign en[QB+1] = en_dn;
  assign en_up    = en[0];

  for (genvar s = 0; s <= QB; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Entry stage: a quotient that needs more than QB bits only has to be flagged.
  for (genvar k = 0; k < 3; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (en[0]) begin
        rem_r[0][k] <= in_num[k];
        quo_r[0][k] <= '0;
        ovf_r[0][k] <= {1'b0, in_num[k]} >= ((NUM_W+1)'(in_den) << QB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= in_side;
      den_r[0]  <= in_den;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 1; s <= QB; s++) begin : g_step
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [NUM_W:0] trial;

      assign trial = {1'b0, rem_r[s-1][k]} - ((NUM_W+1)'(den_r[s-1]) << (QB - s));

      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_r[s][k] <= trial[NUM_W] ? rem_r[s-1][k] : trial[NUM_W-1:0];
          quo_r[s][k] <= {quo_r[s-1][k][QB-2:0], !trial[NUM_W]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        side_r[s] <= side_r[s-1];
        den_r[s]  <= den_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
      end
    end
  end

  assign out_valid  = v_r[QB];
  assign out_side   = side_r[QB];
  assign out_quo[0] = quo_r[QB][0];
  assign out_quo[1] = quo_r[QB][1];
  assign out_quo[2] = quo_r[QB][2];
  assign out_ovf    = ovf_r[QB];

endmodule

[sv/vertex_transform_4x4_top.sv]
// Fixed-point 4x4 matrix times vector with optional perspective divide. A new
// transaction is taken every cycle while the output side does not stall. Each
// result passes the multiply and adder-tree registers, a rounding and operand
// setup register, an overflow check, sixteen divider stages (one quotient bit
// per stage, set by the 16-bit saturating quotient range) and the output register.
// The pipeline closes gaps and holds under out_stall without losing data. The
// four row registers reset to the identity matrix at Q8.8 and sit at byte
// addresses 0, 8, 16 and 24 of the 64-bit configuration port; they should only
// be written while no transaction is in flight.
`include "assert_macros.svh"

module vertex_transform_4x4_top #(
  parameter int FRAC_BITS   = 8,
  parameter int COEFF_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  input  logic signed [15:0] in_w,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic               out_zero_w,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int DW    = vt4_pkg::DATA_W;
  localparam int QB    = vt4_pkg::Q_BITS;
  localparam int ACC_W = COEFF_WIDTH + vt4_pkg::VEC_W + 2;
  localparam int NUM_W = ACC_W + QB + FRAC_BITS;
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(2 ** (FRAC_BITS-1));
  localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0] SAT_MIN  = (ACC_W+1)'(-32768);

  // Configuration registers
  logic [vt4_pkg::ROW_W-1:0] row_r [vt4_pkg::NUM_ROWS];
  vt4_pkg::vt4_reg_t         reg_sel;

  assign reg_sel = vt4_pkg::vt4_reg_t'(paddr[4:3]);
  assign pready  = 1'b1;
  assign prdata  = row_r[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= vt4_pkg::ROW0_RESET;
      row_r[1] <= vt4_pkg::ROW1_RESET;
      row_r[2] <= vt4_pkg::ROW2_RESET;
      row_r[3] <= vt4_pkg::ROW3_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        vt4_pkg::REG_ROW0: row_r[0] <= pwdata;
        vt4_pkg::REG_ROW1: row_r[1] <= pwdata;
        vt4_pkg::REG_ROW2: row_r[2] <= pwdata;
        vt4_pkg::REG_ROW3: row_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Matrix product
  logic                    mac_en_up, mac_valid;
  vt4_pkg::vt4_cmd_t       mac_cmd;
  logic signed [ACC_W-1:0] acc [vt4_pkg::NUM_ROWS];
  logic                    p_en;

  vt4_mac #(
    .FRAC_BITS   (FRAC_BITS),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (vt4_pkg::vt4_cmd_t'(in_cmd)),
    .vx        (in_x),
    .vy        (in_y),
    .vz        (in_z),
    .vw        (in_w),
    .rows      (row_r),
    .en_dn     (p_en),
    .en_up     (mac_en_up),
    .out_valid (mac_valid),
    .out_cmd   (mac_cmd),
    .acc       (acc)
  );

  assign in_stall = !mac_en_up;

  // Rounding, saturation and divider operand setup
  logic signed [ACC_W:0]   rsum [4];
  logic signed [ACC_W:0]   rsh  [4];
  logic [DW-1:0]           rsat [4];
  logic [ACC_W-1:0]        mag  [4];
  logic [NUM_W-1:0]        num_nxt [3];
  logic [ACC_W-1:0]        den_nxt;
  vt4_pkg::vt4_side_t      side_nxt;

  logic                    p_v_r;
  vt4_pkg::vt4_side_t      p_side_r;
  logic [NUM_W-1:0]        p_num_r [3];
  logic [ACC_W-1:0]        p_den_r;
  logic                    div_en_up;

  for (genvar k = 0; k < 4; k++) begin : g_round
    always_comb begin
      rsum[k] = (ACC_W+1)'(acc[k]) + RND_HALF;
      rsh[k]  = rsum[k] >>> FRAC_BITS;
      if (rsh[k] > SAT_MAX) begin
        rsat[k] = vt4_pkg::Q_POS_MAX;
      end else if (rsh[k] < SAT_MIN) begin
        rsat[k] = vt4_pkg::Q_NEG_MAX;
      end else begin
        rsat[k] = rsh[k][DW-1:0];
      end
      mag[k] = acc[k][ACC_W-1] ? ACC_W'(-acc[k]) : ACC_W'(acc[k]);
    end
  end

  // Rounded quotient floor((2|p|*2^F + |w|) / (2|w|)) as a plain integer division.
  for (genvar k = 0; k < 3; k++) begin : g_num
    assign num_nxt[k] = (NUM_W'(mag[k]) << (FRAC_BITS + 1)) + NUM_W'(mag[3]);
    assign side_nxt.neg[k] = acc[k][ACC_W-1] ^ acc[3][ACC_W-1];
  end

  assign den_nxt         = mag[3] << 1;
  assign side_nxt.cmd    = mac_cmd;
  assign side_nxt.zero_w = (mac_cmd == vt4_pkg::CMD_PERSP) && (acc[3] == '0);
  assign side_nxt.rnd    = {rsat[3], rsat[2], rsat[1], rsat[0]};

  assign p_en = !p_v_r || div_en_up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_en) begin
      p_v_r <= mac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      p_side_r <= side_nxt;
      p_num_r  <= num_nxt;
      p_den_r  <= den_nxt;
    end
  end

  // Perspective divide
  logic                  d_valid;
  vt4_pkg::vt4_side_t    d_side;
  logic [QB-1:0]         d_quo [3];
  logic [2:0]            d_ovf;
  logic                  out_en;

  vt4_div #(
    .ACC_W (ACC_W),
    .NUM_W (NUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_v_r),
    .in_side   (p_side_r),
    .in_num    (p_num_r),
    .in_den    (p_den_r),
    .en_dn     (out_en),
    .en_up     (div_en_up),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quo   (d_quo),
    .out_ovf   (d_ovf)
  );

  // Output register
  logic          out_valid_r;
  logic [DW-1:0] res_nxt [3];
  logic [DW-1:0] out_xyz_r [3];
  logic [DW-1:0] out_w_r;
  logic          out_zero_w_r;

  assign out_en = !out_valid_r || !out_stall;

  for (genvar k = 0; k < 3; k++) begin : g_res
    always_comb begin
      if (d_side.cmd == vt4_pkg::CMD_HOMOG) begin
        res_nxt[k] = d_side.rnd[k];
      end else if (d_side.zero_w) begin
        res_nxt[k] = '0;
      end else if (d_side.neg[k]) begin
        res_nxt[k] = (d_ovf[k] || (d_quo[k] > vt4_pkg::Q_NEG_MAX)) ?
                     vt4_pkg::Q_NEG_MAX : DW'(0) - DW'(d_quo[k]);
      end else begin
        res_nxt[k] = (d_ovf[k] || (d_quo[k] > vt4_pkg::Q_POS_MAX)) ?
                     vt4_pkg::Q_POS_MAX : DW'(d_quo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_xyz_r    <= res_nxt;
      out_w_r      <= d_side.rnd[3];
      out_zero_w_r <= d_side.zero_w;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_xyz_r[0];
  assign out_y      = out_xyz_r[1];
  assign out_z      = out_xyz_r[2];
  assign out_w      = out_w_r;
  assign out_zero_w = out_zero_w_r;

  `VT4_ASSERT(a_accept_when_out_empty, clk, rst_n, !out_valid_r |-> !in_stall, "input stalled with empty output register")
  `VT4_ASSERT(a_zero_w_outputs, clk, rst_n, out_valid_r && out_zero_w_r |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0 && out_w == 16'sd0, "zero w result not cleared")
  `VT4_ASSERT(a_zero_w_den, clk, rst_n, p_v_r && p_side_r.zero_w |-> p_den_r == '0, "zero w flag with nonzero divisor")
  `VT4_NEVER(a_zero_w_homog, clk, rst_n, p_v_r && p_side_r.zero_w && p_side_r.cmd == vt4_pkg::CMD_HOMOG, "zero w flag on four-component transaction")

endmodule

[tb/sv/tb_vertex_transform_4x4_top.sv]
module tb_vertex_transform_4x4_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS      = 8;
  localparam int COEFF_WIDTH    = 16;
  localparam int PIPE_LATENCY   = 22;
  localparam int QUIET_LIMIT    = 2000;
  localparam int PHASE_VERTICES = 100;
  localparam int NUM_PHASES     = 6;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;
  typedef enum int {MAT_RANDOM, MAT_PROJECTIVE, MAT_TINY_W} matrix_style_t;

  typedef struct packed {
    logic [vt4_pkg::DATA_W-1:0] x;
    logic [vt4_pkg::DATA_W-1:0] y;
    logic [vt4_pkg::DATA_W-1:0] z;
    logic [vt4_pkg::DATA_W-1:0] w;
    logic                       zero_w;
  } vertex_result_t;

  // Keeps its own copy of the matrix and the transformed vertices still owed by the block.
  class vertex_ledger;
    logic [vt4_pkg::ROW_W-1:0] rows [vt4_pkg::NUM_ROWS];
    vertex_result_t            awaited [$];
    int                        mismatches;

    function new();
      rows[0] = vt4_pkg::ROW0_RESET;
      rows[1] = vt4_pkg::ROW1_RESET;
      rows[2] = vt4_pkg::ROW2_RESET;
      rows[3] = vt4_pkg::ROW3_RESET;
      mismatches = 0;
    endfunction

    function longint coeff(int r, int c);
      logic signed [COEFF_WIDTH-1:0] lane;
      lane = rows[r][vt4_pkg::LANE_W*c +: COEFF_WIDTH];
      return longint'(lane);
    endfunction

    // Drops FRAC_BITS fraction bits, rounding half toward plus infinity.
    function longint rescale(longint a);
      return (a + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function logic [vt4_pkg::DATA_W-1:0] clamp16(longint v);
      if (v > 32767) return vt4_pkg::Q_POS_MAX;
      if (v < -32768) return vt4_pkg::Q_NEG_MAX;
      return v[vt4_pkg::DATA_W-1:0];
    endfunction

    // Rounds the magnitude of the quotient to nearest with ties away from zero.
    function logic [vt4_pkg::DATA_W-1:0] quotient(longint num, longint den);
      longint          n;
      longint unsigned un;
      longint unsigned ud;
      longint unsigned q;
      longint unsigned neg_q;
      bit              neg;
      n = num * (longint'(1) << FRAC_BITS);
      neg = (n < 0) != (den < 0);
      un = (n < 0) ? -n : n;
      ud = (den < 0) ? -den : den;
      q = (2 * un + ud) / (2 * ud);
      neg_q = -q;
      if (neg) return (q > 32768) ? vt4_pkg::Q_NEG_MAX : neg_q[vt4_pkg::DATA_W-1:0];
      return (q > 32767) ? vt4_pkg::Q_POS_MAX : q[vt4_pkg::DATA_W-1:0];
    endfunction

    function void note_vertex(vt4_pkg::vt4_cmd_t cmd, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z,
                              logic signed [15:0] w);
      longint         vec [4];
      longint         prod [vt4_pkg::NUM_ROWS];
      vertex_result_t want;
      vec[0] = x;
      vec[1] = y;
      vec[2] = z;
      vec[3] = (cmd == vt4_pkg::CMD_PERSP) ? (longint'(1) << FRAC_BITS) : longint'(w);
      for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
        prod[r] = 0;
        for (int c = 0; c < 4; c++) prod[r] += coeff(r, c) * vec[c];
      end
      want.w = clamp16(rescale(prod[3]));
      want.zero_w = 1'b0;
      if (cmd == vt4_pkg::CMD_HOMOG) begin
        want.x = clamp16(rescale(prod[0]));
        want.y = clamp16(rescale(prod[1]));
        want.z = clamp16(rescale(prod[2]));
      end else if (prod[3] == 0) begin
        want.x = '0;
        want.y = '0;
        want.z = '0;
        want.zero_w = 1'b1;
      end else begin
        want.x = quotient(prod[0], prod[3]);
        want.y = quotient(prod[1], prod[3]);
        want.z = quotient(prod[2], prod[3]);
      end
      awaited.push_back(want);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [15:0] w, logic zw);
      vertex_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none",
                 $time, " actual x=%h y=%h z=%h w=%h zero_w=%b", x, y, z, w, zw);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare("out_x", want.x, x);
      compare("out_y", want.y, y);
      compare("out_z", want.z, z);
      compare("out_w", want.w, w);
      compare("out_zero_w", 16'(want.zero_w), 16'(zw));
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_cmd     = 1'b0;
  logic signed [15:0] in_x       = '0;
  logic signed [15:0] in_y       = '0;
  logic signed [15:0] in_z       = '0;
  logic signed [15:0] in_w       = '0;
  logic               out_stall  = 1'b0;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [4:0]         paddr      = '0;
  logic [63:0]        pwdata     = '0;
  wire                in_stall;
  wire                out_valid;
  wire signed [15:0]  out_x;
  wire signed [15:0]  out_y;
  wire signed [15:0]  out_z;
  wire signed [15:0]  out_w;
  wire                out_zero_w;
  wire [63:0]         prdata;
  wire                pready;

  vertex_ledger              ledger = new();
  logic [vt4_pkg::ROW_W-1:0] next_rows [vt4_pkg::NUM_ROWS];
  int                        burst_left   = 0;
  int                        quiet_cycles = 0;
  stall_mode_t               stall_mode   = STALL_NONE;
  int                        mode_left    = 0;
  logic [3:0]                stall_phase  = '0;

  vertex_transform_4x4_top #(
    .FRAC_BITS  (FRAC_BITS),
    .COEFF_WIDTH(COEFF_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_w      (in_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .out_zero_w(out_zero_w),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        ledger.note_vertex(vt4_pkg::vt4_cmd_t'(in_cmd), in_x, in_y, in_z, in_w);
      end
      if (out_valid && !out_stall) ledger.check_vertex(out_x, out_y, out_z, out_w, out_zero_w);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The output side switches between stall patterns, picking a new one at random each time the current one runs out.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 4'd1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
      default:     out_stall <= (stall_phase < 4'd11);
    endcase
  end

  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] small_coeff(int unsigned mag);
    return 16'($urandom_range(0, 2 * mag) - mag);
  endfunction

  function automatic void choose_matrix(matrix_style_t style);
    for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
      case (style)
        MAT_RANDOM: next_rows[r] = {$urandom, $urandom};
        MAT_PROJECTIVE: begin
          if (r == 3) next_rows[r] = {small_coeff(300), small_coeff(300), 32'h0};
          else next_rows[r] = {small_coeff(512), small_coeff(512), small_coeff(512),
                               small_coeff(512)};
        end
        default: begin
          // A w row with a single tiny coefficient makes w vanish or nearly vanish.
          if (r == 3) next_rows[r] = {48'h0, small_coeff(3)};
          else next_rows[r] = {$urandom, $urandom};
        end
      endcase
    end
  endfunction

  task automatic load_matrix();
    for (int r = 0; r < vt4_pkg::NUM_ROWS; r++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {vt4_pkg::vt4_reg_t'(r), 3'b000};
      pwdata <= next_rows[r];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      ledger.rows[r] = next_rows[r];
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_vertex(vt4_pkg::vt4_cmd_t cmd, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [15:0] w);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    in_w <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_random_vertex();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end
    burst_left--;
    send_vertex(vt4_pkg::vt4_cmd_t'($urandom_range(0, 1)), pick_component(),
                pick_component(), pick_component(), pick_component());
  endtask

  // The extra edge lets the monitor record the last accepted transaction first.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Identity matrix out of reset.
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h7FFF, 16'h8000, 16'h0100, 16'h1234);
    send_vertex(vt4_pkg::CMD_PERSP, 16'hFF80, 16'h0080, 16'h0000, 16'h8000);
    drain_results();

    next_rows = '{64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                  64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF};
    load_matrix();
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    drain_results();

    next_rows = '{64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                  64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000};
    load_matrix();
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    drain_results();

    // Row 3 weighs only x, so x picks a zero, tiny or negative tiny w.
    next_rows = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  64'h0000_0000_0000_0001};
    load_matrix();
    send_vertex(vt4_pkg::CMD_PERSP, 16'h0000, 16'h1234, 16'hC000, 16'h7FFF);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h0001, 16'h7FFF, 16'h8000, 16'h0000);
    send_vertex(vt4_pkg::CMD_PERSP, 16'hFFFF, 16'h0100, 16'hFF00, 16'h0000);
    send_vertex(vt4_pkg::CMD_HOMOG, 16'h0000, 16'h5555, 16'hAAAA, 16'h0000);
    send_vertex(vt4_pkg::CMD_PERSP, 16'h0100, 16'h0000, 16'h0000, 16'h0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      choose_matrix(matrix_style_t'(p % 3));
      load_matrix();
      repeat (PHASE_VERTICES) send_random_vertex();
    end

    drain_results();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[vertex_transform_4x4_top.f]
+incdir+sv
sv/vt4_pkg.sv
sv/vt4_mac.sv
sv/vt4_div.sv
sv/vertex_transform_4x4_top.sv
tb/sv/tb_vertex_transform_4x4_top.sv
